// ===== src/turtle_line_plotter_top_macros.svh =====
// ----------------------------------------------------------------------------
// turtle_line_plotter_top_macros.svh
// Assertion macros used by the plotter controller.
// ----------------------------------------------------------------------------
`ifndef TURTLE_LINE_PLOTTER_TOP_MACROS_SVH
`define TURTLE_LINE_PLOTTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tlp assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define TLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tlp assertion failed");

`endif

// ===== src/tlp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlp_pkg
// Types and codes shared by the turtle plotter controller and datapath.
// ----------------------------------------------------------------------------
package tlp_pkg;

	// Command codes; code 7 is unused and does nothing
	typedef enum logic [2:0] {
		ACT_PEN_DOWN   = 3'd0,
		ACT_PEN_UP     = 3'd1,
		ACT_TURN_RIGHT = 3'd2,
		ACT_TURN_LEFT  = 3'd3,
		ACT_MOVE       = 3'd4,
		ACT_CLEAR      = 3'd5,
		ACT_READ       = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		HEAD_UP    = 2'd0,
		HEAD_RIGHT = 2'd1,
		HEAD_DOWN  = 2'd2,
		HEAD_LEFT  = 2'd3
	} heading_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DRAW,
		ST_DRAIN,
		ST_PROBE,
		ST_RESULT
	} tlp_state_t;

	// Command beat payload
	typedef struct packed {
		logic [2:0] action;
		logic [7:0] step_count;
		logic [5:0] probe_row;
		logic [5:0] probe_column;
	} cmd_beat_t;

	// Result beat payload
	typedef struct packed {
		logic       pixel;
		logic [5:0] pose_row;
		logic [5:0] pose_column;
		logic [1:0] pose_heading;
		logic       pen_lowered;
	} res_beat_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take;   // capture the input beat
		logic exec;   // apply command, set up the draw span
		logic draw;   // read one canvas row of the span
		logic probe;  // read the probed canvas row
		logic emit;   // load the result register
	} tlp_ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		logic draw_needed;
		logic draw_last;
		logic out_free;
	} tlp_stat_t;

endpackage

// ===== src/tlp_if.sv =====
// ----------------------------------------------------------------------------
// tlp_if
// Valid/ready channels for plotter commands and results.
// ----------------------------------------------------------------------------
interface tlp_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] step_count;
	logic [5:0] probe_row;
	logic [5:0] probe_column;

	modport source (output valid, action, step_count, probe_row, probe_column, input ready);
	modport sink (input valid, action, step_count, probe_row, probe_column, output ready);
endinterface

interface tlp_res_if;
	logic       valid;
	logic       ready;
	logic       pixel;
	logic [5:0] pose_row;
	logic [5:0] pose_column;
	logic [1:0] pose_heading;
	logic       pen_lowered;

	modport source (output valid, pixel, pose_row, pose_column, pose_heading, pen_lowered,
		input ready);
	modport sink (input valid, pixel, pose_row, pose_column, pose_heading, pen_lowered,
		output ready);
endinterface

// ===== src/tlp_datapath.sv =====
// ----------------------------------------------------------------------------
// tlp_datapath
// Pose registers, row-wide canvas memory with per-row valid bits, draw
// span logic with a read-modify-write stage, and the result register.
// ----------------------------------------------------------------------------
module tlp_datapath import tlp_pkg::*; #(
	parameter int GRID_SIZE = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tlp_ctrl_t ctrl,
	output tlp_stat_t stat,
	input  cmd_beat_t cmd_beat,
	output res_beat_t res_beat,
	output logic      res_valid,
	input  logic      res_ready
);

	localparam int PW = $clog2(GRID_SIZE);
	localparam int SW = ((PW > 8) ? PW : 8) + 1;
	localparam logic [PW-1:0] LAST_P = PW'(GRID_SIZE - 1);
	localparam logic [SW-1:0] LAST_W = SW'(GRID_SIZE - 1);

	// captured beat
	action_t         act_q;
	logic [7:0]      dist_q;
	logic [5:0]      prow_q;
	logic [5:0]      pcol_q;

	// pose
	heading_t        heading_q;
	logic            pen_q;
	logic [PW-1:0]   row_q;
	logic [PW-1:0]   col_q;

	// draw span
	logic [PW-1:0]       row_cnt_q;
	logic [PW-1:0]       row_end_q;
	logic [GRID_SIZE-1:0] mask_q;

	// canvas
	logic [GRID_SIZE-1:0] canvas_mem [GRID_SIZE];
	logic [GRID_SIZE-1:0] valid_q;
	logic [GRID_SIZE-1:0] rd_data_s1;
	logic                 rd_valid_s1;
	logic                 wr_en_s1;
	logic [PW-1:0]        wr_addr_s1;
	logic                 probe_ok_s1;

	// result register
	res_beat_t res_q;
	logic      res_valid_q;

	// move set-up signals
	logic [SW-1:0]        diff_r, diff_c, sum_r, sum_c;
	logic [PW-1:0]        up_end, dn_end, lf_end, rt_end;
	logic [PW-1:0]        new_row, new_col, span_lo, span_hi, clo, chi;
	logic [GRID_SIZE-1:0] span_mask;
	logic                 probe_ok;
	logic [PW-1:0]        probe_idx, pcol_idx, rd_addr;
	logic                 pixel_bit;

	// end of move along each heading, clamped at the edges
	always_comb begin
		diff_r = SW'(row_q) - SW'(dist_q);
		diff_c = SW'(col_q) - SW'(dist_q);
		sum_r  = SW'(row_q) + SW'(dist_q);
		sum_c  = SW'(col_q) + SW'(dist_q);
		up_end = diff_r[SW-1] ? '0 : diff_r[PW-1:0];
		lf_end = diff_c[SW-1] ? '0 : diff_c[PW-1:0];
		dn_end = (sum_r > LAST_W) ? LAST_P : sum_r[PW-1:0];
		rt_end = (sum_c > LAST_W) ? LAST_P : sum_c[PW-1:0];
	end

	// span of rows and column mask for the move
	always_comb begin
		new_row   = row_q;
		new_col   = col_q;
		span_lo   = row_q;
		span_hi   = row_q;
		clo       = col_q;
		chi       = col_q;
		span_mask = '0;
		case (heading_q)
			HEAD_UP: begin
				new_row = up_end;
				span_lo = up_end;
			end
			HEAD_DOWN: begin
				new_row = dn_end;
				span_hi = dn_end;
			end
			HEAD_RIGHT: begin
				new_col = rt_end;
				chi     = rt_end;
			end
			default: begin
				new_col = lf_end;
				clo     = lf_end;
			end
		endcase
		if (heading_q == HEAD_UP || heading_q == HEAD_DOWN) begin
			span_mask = GRID_SIZE'(1) << col_q;
		end else begin
			span_mask = ({GRID_SIZE{1'b1}} << clo) & ({GRID_SIZE{1'b1}} >> (LAST_P - chi));
		end
	end

	// probe addressing
	always_comb begin
		probe_ok  = (32'(prow_q) < GRID_SIZE) && (32'(pcol_q) < GRID_SIZE);
		probe_idx = probe_ok ? PW'(prow_q) : '0;
		pcol_idx  = probe_ok ? PW'(pcol_q) : '0;
		rd_addr   = ctrl.probe ? probe_idx : row_cnt_q;
		pixel_bit = probe_ok_s1 & rd_valid_s1 & rd_data_s1[pcol_idx];
	end

	// captured beat, no reset needed
	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			act_q  <= action_t'(cmd_beat.action);
			dist_q <= cmd_beat.step_count;
			prow_q <= cmd_beat.probe_row;
			pcol_q <= cmd_beat.probe_column;
		end
	end

	// pose and span registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= HEAD_RIGHT;
			pen_q     <= 1'b1;
			row_q     <= '0;
			col_q     <= '0;
			row_cnt_q <= '0;
			row_end_q <= '0;
			mask_q    <= '0;
		end else if (ctrl.exec) begin
			case (act_q)
				ACT_PEN_DOWN:   pen_q <= 1'b1;
				ACT_PEN_UP:     pen_q <= 1'b0;
				ACT_TURN_RIGHT: heading_q <= heading_t'(heading_q + 2'd1);
				ACT_TURN_LEFT:  heading_q <= heading_t'(heading_q - 2'd1);
				ACT_MOVE: begin
					row_q     <= new_row;
					col_q     <= new_col;
					row_cnt_q <= span_lo;
					row_end_q <= span_hi;
					mask_q    <= span_mask;
				end
				default: ;
			endcase
		end else if (ctrl.draw) begin
			row_cnt_q <= row_cnt_q + 1'b1;
		end
	end

	// row valid bits: cleared by reset and the clear command, set on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.exec && act_q == ACT_CLEAR) begin
			valid_q <= '0;
		end else if (wr_en_s1) begin
			valid_q[wr_addr_s1] <= 1'b1;
		end
	end

	// write stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= ctrl.draw;
		end
	end

	// canvas memory: one read port, one write port, registered read
	always_ff @(posedge clk) begin
		if (ctrl.draw || ctrl.probe) begin
			rd_data_s1  <= canvas_mem[rd_addr];
			rd_valid_s1 <= valid_q[rd_addr];
			probe_ok_s1 <= probe_ok;
		end
		if (ctrl.draw) begin
			wr_addr_s1 <= row_cnt_q;
		end
		if (wr_en_s1) begin
			canvas_mem[wr_addr_s1] <= (rd_valid_s1 ? rd_data_s1 : '0) | mask_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			res_q.pixel        <= pixel_bit;
			res_q.pose_row     <= 6'(row_q);
			res_q.pose_column  <= 6'(col_q);
			res_q.pose_heading <= heading_q;
			res_q.pen_lowered  <= pen_q;
		end
	end

	assign res_beat  = res_q;
	assign res_valid = res_valid_q;

	assign stat.draw_needed = (act_q == ACT_MOVE) && pen_q;
	assign stat.draw_last   = (row_cnt_q == row_end_q);
	assign stat.out_free    = !res_valid_q || res_ready;

endmodule

// ===== src/tlp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlp_ctrl
// Sequencer for one command: capture, execute, draw the span row by row,
// drain the write stage, read the probe row and hand over the result.
// ----------------------------------------------------------------------------
`include "turtle_line_plotter_top_macros.svh"

module tlp_ctrl import tlp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output tlp_ctrl_t ctrl,
	input  tlp_stat_t stat
);

	tlp_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.take = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctrl.exec = 1'b1;
				state_d   = stat.draw_needed ? ST_DRAW : ST_PROBE;
			end
			ST_DRAW: begin
				ctrl.draw = 1'b1;
				if (stat.draw_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_PROBE;
			end
			ST_PROBE: begin
				ctrl.probe = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					ctrl.emit = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// a captured beat is always executed next
	`TLP_ASSERT_NEXT(a_take_exec, clk, arst_n, ctrl.take, state_q == ST_EXEC)
	// the result register is never overwritten while still held
	`TLP_ASSERT_NOW(a_emit_free, clk, arst_n, ctrl.emit, stat.out_free)
	// drain only follows the last row of a draw span
	`TLP_ASSERT_NOW(a_drain_after_draw, clk, arst_n, state_q == ST_DRAIN,
		$past(state_q) == ST_DRAW && $past(stat.draw_last))
	// the probe read never overlaps a pending row write
	`TLP_ASSERT_NOW(a_probe_no_draw, clk, arst_n, ctrl.probe,
		$past(state_q) != ST_DRAW)

endmodule

// ===== src/turtle_line_plotter_top.sv =====
// ----------------------------------------------------------------------------
// turtle_line_plotter_top
// Turtle plotter over a square one-bit canvas, held as one memory row per
// canvas row.
//
//   channel | dir | beat contents
//   cmd     | in  | action, step_count, probe_row, probe_column
//   res     | out | pixel, pose_row, pose_column, pose_heading, pen_lowered
//
// One command at a time. A command runs from capture through the execute, probe
// and result states; a pen-down move, between execute and probe, draws each
// canvas row it touches (1 if horizontal, up to GRID_SIZE if vertical) through
// the one-row-per-cycle memory port and then drains the write stage.
// Reset blanks the canvas at once through per-row valid bits; clear does too.
// A new command is taken while the last result waits; a stalled result holds
// the next one in its final state.
// ----------------------------------------------------------------------------
module turtle_line_plotter_top import tlp_pkg::*; #(
	parameter int GRID_SIZE = 64
) (
	input logic       clk,
	input logic       arst_n,
	tlp_cmd_if.sink   cmd,
	tlp_res_if.source res
);

	tlp_ctrl_t ctrl;
	tlp_stat_t stat;
	cmd_beat_t cmd_beat;
	res_beat_t res_beat;

	assign cmd_beat.action       = cmd.action;
	assign cmd_beat.step_count   = cmd.step_count;
	assign cmd_beat.probe_row    = cmd.probe_row;
	assign cmd_beat.probe_column = cmd.probe_column;

	tlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.ctrl     (ctrl),
		.stat     (stat)
	);

	tlp_datapath #(
		.GRID_SIZE (GRID_SIZE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.cmd_beat  (cmd_beat),
		.res_beat  (res_beat),
		.res_valid (res.valid),
		.res_ready (res.ready)
	);

	assign res.pixel        = res_beat.pixel;
	assign res.pose_row     = res_beat.pose_row;
	assign res.pose_column  = res_beat.pose_column;
	assign res.pose_heading = res_beat.pose_heading;
	assign res.pen_lowered  = res_beat.pen_lowered;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the turtle plotter. Commands are queued up front,
// driven over the valid/ready command channel with random gaps, and every
// result beat is compared against an in-bench model of pose, pen and canvas.
// ----------------------------------------------------------------------------
module tb;
	import tlp_pkg::*;

	localparam int          GRID_SIZE    = 64;
	localparam int          RANDOM_ITEMS = 1850;
	localparam int          CALM_TAIL    = 250;
	localparam int          SETTLE       = 100;
	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          PRINT_CAP    = 40;
	localparam logic [2:0]  ACT_UNUSED   = 3'd7;

	typedef struct {
		cmd_beat_t beat;
		bit        hold_off;   // wait for every result before sending
	} queued_cmd_t;

	logic clk = 1'b0;
	logic arst_n;

	tlp_cmd_if cmd_ch ();
	tlp_res_if res_ch ();

	turtle_line_plotter_top #(
		.GRID_SIZE(GRID_SIZE)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.res   (res_ch)
	);

	always #6 clk = ~clk;

	// Plotter model state
	bit [GRID_SIZE-1:0] sheet [GRID_SIZE];
	heading_t           head_model = HEAD_RIGHT;
	bit                 pen_model  = 1'b1;
	int                 row_model  = 0;
	int                 col_model  = 0;

	queued_cmd_t        cmd_backlog [$];
	res_beat_t          awaited_plots [$];
	int                 cmds_taken = 0;
	int                 plots_seen = 0;
	int                 calm_from  = 0;
	int                 fail_count = 0;
	int                 cycle_count = 0;
	int                 send_gap = 0;
	int                 stall_gap = 0;

	// Apply one command to the model and return the beat it should produce
	function automatic res_beat_t plot_command(cmd_beat_t c);
		int        travel;
		int        stop;
		res_beat_t r;
		travel = c.step_count;
		case (c.action)
			ACT_PEN_DOWN:   pen_model = 1'b1;
			ACT_PEN_UP:     pen_model = 1'b0;
			ACT_TURN_RIGHT: head_model = (head_model == HEAD_LEFT) ? HEAD_UP
				: heading_t'(head_model + 1);
			ACT_TURN_LEFT:  head_model = (head_model == HEAD_UP) ? HEAD_LEFT
				: heading_t'(head_model - 1);
			ACT_CLEAR: begin
				for (int i = 0; i < GRID_SIZE; i++)
					sheet[i] = '0;
			end
			ACT_MOVE: begin
				// travel clamps at the edge; with the pen down both end cells are inked
				case (head_model)
					HEAD_UP: begin
						stop = (travel > row_model) ? 0 : row_model - travel;
						if (pen_model)
							for (int i = stop; i <= row_model; i++)
								sheet[i][col_model] = 1'b1;
						row_model = stop;
					end
					HEAD_RIGHT: begin
						stop = (col_model + travel > GRID_SIZE - 1) ? GRID_SIZE - 1
							: col_model + travel;
						if (pen_model)
							for (int i = col_model; i <= stop; i++)
								sheet[row_model][i] = 1'b1;
						col_model = stop;
					end
					HEAD_DOWN: begin
						stop = (row_model + travel > GRID_SIZE - 1) ? GRID_SIZE - 1
							: row_model + travel;
						if (pen_model)
							for (int i = row_model; i <= stop; i++)
								sheet[i][col_model] = 1'b1;
						row_model = stop;
					end
					default: begin
						stop = (travel > col_model) ? 0 : col_model - travel;
						if (pen_model)
							for (int i = stop; i <= col_model; i++)
								sheet[row_model][i] = 1'b1;
						col_model = stop;
					end
				endcase
			end
			default: ;
		endcase
		r.pixel        = sheet[c.probe_row][c.probe_column];
		r.pose_row     = row_model[5:0];
		r.pose_column  = col_model[5:0];
		r.pose_heading = head_model;
		r.pen_lowered  = pen_model;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (fail_count < PRINT_CAP)
			$display("MISMATCH beat %0d %s: got %0d want %0d", plots_seen, what, got, want);
		fail_count++;
	endtask

	task automatic check_field(string what, int got, int want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	task automatic add_cmd(logic [2:0] act, int step, int prow, int pcol, bit hold);
		queued_cmd_t q;
		q.beat.action       = act;
		q.beat.step_count   = step[7:0];
		q.beat.probe_row    = prow[5:0];
		q.beat.probe_column = pcol[5:0];
		q.hold_off          = hold;
		cmd_backlog.push_back(q);
	endtask

	// Command driver
	always @(posedge clk or negedge arst_n) begin : drive
		queued_cmd_t item;
		bit          calm;
		bit          drained;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				awaited_plots.push_back(plot_command({cmd_ch.action, cmd_ch.step_count,
					cmd_ch.probe_row, cmd_ch.probe_column}));
				cmds_taken <= cmds_taken + 1;
			end
			calm    = cmds_taken >= calm_from;
			drained = (cmds_taken + (cmd_ch.valid && cmd_ch.ready))
				== (plots_seen + (res_ch.valid && res_ch.ready));
			if (!(cmd_ch.valid && !cmd_ch.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_ch.valid <= 1'b0;
				end else if (cmd_backlog.size() == 0) begin
					cmd_ch.valid <= 1'b0;
				end else if (cmd_backlog[0].hold_off && !drained) begin
					cmd_ch.valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 3);
					cmd_ch.valid <= 1'b0;
				end else begin
					item = cmd_backlog.pop_front();
					cmd_ch.valid        <= 1'b1;
					cmd_ch.action       <= item.beat.action;
					cmd_ch.step_count   <= item.beat.step_count;
					cmd_ch.probe_row    <= item.beat.probe_row;
					cmd_ch.probe_column <= item.beat.probe_column;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin : collect
		res_beat_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_gap = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				plots_seen <= plots_seen + 1;
				if (awaited_plots.size() == 0) begin
					report_mismatch("result with nothing pending", 1, 0);
				end else begin
					want = awaited_plots.pop_front();
					check_field("pixel", res_ch.pixel, want.pixel);
					check_field("pose_row", res_ch.pose_row, want.pose_row);
					check_field("pose_column", res_ch.pose_column, want.pose_column);
					check_field("pose_heading", res_ch.pose_heading, want.pose_heading);
					check_field("pen_lowered", res_ch.pen_lowered, want.pen_lowered);
				end
			end
			if (stall_gap > 0) begin
				stall_gap--;
				res_ch.ready <= 1'b0;
			end else if (cmds_taken < calm_from && $urandom_range(0, 5) == 0) begin
				stall_gap = $urandom_range(0, 3);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Run timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		int         pick;
		int         step;
		logic [2:0] act;
		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.action       = ACT_READ;
		cmd_ch.step_count   = '0;
		cmd_ch.probe_row    = '0;
		cmd_ch.probe_column = '0;
		res_ch.ready        = 1'b0;

		// Directed: edges, wraps, clamps, zero move, clear, unused code
		add_cmd(ACT_READ,       0,   0,  0,  0);
		add_cmd(ACT_MOVE,       0,   0,  0,  0);   // zero move inks start cell
		add_cmd(ACT_MOVE,       255, 0,  63, 0);   // clamp at right edge
		add_cmd(ACT_TURN_RIGHT, 0,   0,  62, 0);
		add_cmd(ACT_MOVE,       255, 63, 63, 0);   // clamp at bottom
		add_cmd(ACT_TURN_RIGHT, 0,   32, 63, 0);
		add_cmd(ACT_MOVE,       10,  63, 53, 0);
		add_cmd(ACT_TURN_RIGHT, 0,   63, 52, 0);   // left wraps to up
		add_cmd(ACT_TURN_LEFT,  0,   63, 54, 0);   // up wraps to left
		add_cmd(ACT_PEN_UP,     0,   0,  0,  0);
		add_cmd(ACT_MOVE,       255, 63, 0,  0);   // pen up: no ink
		add_cmd(ACT_PEN_DOWN,   0,   63, 0,  0);
		add_cmd(ACT_TURN_RIGHT, 0,   63, 0,  0);
		add_cmd(ACT_MOVE,       255, 32, 0,  0);   // clamp at top
		add_cmd(ACT_UNUSED,     255, 63, 63, 0);
		add_cmd(ACT_MOVE,       1,   0,  0,  0);   // already at the edge
		add_cmd(ACT_CLEAR,      0,   0,  0,  0);
		add_cmd(ACT_READ,       0,   63, 63, 0);
		add_cmd(ACT_TURN_LEFT,  0,   0,  0,  0);
		add_cmd(ACT_MOVE,       170, 0,  0,  0);   // left edge clamp
		add_cmd(ACT_TURN_LEFT,  0,   0,  1,  0);
		add_cmd(ACT_MOVE,       85,  42, 0,  0);
		add_cmd(ACT_READ,       0,   21, 0,  0);

		// Random strokes: mostly moves and turns with the pen down, rare clears
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 199);
			step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 16);
			if (pick < 80)
				act = ACT_MOVE;
			else if (pick < 100)
				act = ACT_TURN_RIGHT;
			else if (pick < 120)
				act = ACT_TURN_LEFT;
			else if (pick < 134)
				act = ACT_PEN_DOWN;
			else if (pick < 142)
				act = ACT_PEN_UP;
			else if (pick < 194)
				act = ACT_READ;
			else if (pick < 199)
				act = ACT_UNUSED;
			else
				act = ACT_CLEAR;
			add_cmd(act, step, $urandom_range(0, GRID_SIZE - 1),
				$urandom_range(0, GRID_SIZE - 1), n % 400 == 0);
		end
		calm_from = cmd_backlog.size() - CALM_TAIL;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || cmd_ch.valid || cmds_taken != plots_seen)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (awaited_plots.size() != 0)
			report_mismatch("results never returned", 0, awaited_plots.size());

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/tlp_pkg.sv
src/tlp_if.sv
src/tlp_datapath.sv
src/tlp_ctrl.sv
src/turtle_line_plotter_top.sv
test/tb.sv
